// ===== hw/rtl/bors_pkg.sv =====
// Shared types and constants for the block occupancy release scanner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bors_pkg;

   // Sections per side: default, and the ceiling set by one status byte per side
   localparam int SECTIONS_PER_SIDE_DEF = 8;
   localparam int LANES_MAX             = 8;
   localparam int SIDES                 = 2;
   localparam int TIME_W                = 8;
   localparam int STATUS_W              = SIDES * LANES_MAX;
   localparam int REQ_W                 = 3;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_TICK = 3'd0;
   localparam logic [REQ_W-1:0] REQ_SCAN = 3'd1;
   localparam logic [REQ_W-1:0] REQ_RISE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FALL = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LOAD = 3'd4;

   // Identification pattern held in the status word after reset
   localparam logic [7:0]          ID_LOW       = "H";
   localparam logic [7:0]          ID_HIGH      = "P";
   localparam logic [STATUS_W-1:0] STATUS_RESET = {ID_HIGH, ID_LOW};
   localparam logic [TIME_W-1:0]   TIME_RESET   = 8'd1;

   // Per-side lane control, produced by the sequencer for one transfer
   typedef struct packed {
      logic              tick_adv;   // timers of this side count up
      logic              scan_en;    // this side is being scanned
      logic              rel_en;     // power present: release check on this side
      logic [TIME_W-1:0] time_now;
      logic [TIME_W-1:0] restart;    // timer value for an occupied section
   } bors_lane_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bors_if.sv =====
// Valid/ready channel interfaces for request and response transfers.
// Depends on bors_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bors_req_if;
   import bors_pkg::*;
   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [7:0]       block_levels;
   logic             power_check_level;
   logic             serial_in;
   logic             load_level;

   modport source (output valid, req_type, block_levels, power_check_level,
                   serial_in, load_level, input ready);
   modport sink   (input valid, req_type, block_levels, power_check_level,
                   serial_in, load_level, output ready);
endinterface

interface bors_rsp_if;
   import bors_pkg::*;
   logic                valid;
   logic                ready;
   logic                serial_out;
   logic [STATUS_W-1:0] occupancy;
   logic                active_side;

   modport source (output valid, serial_out, occupancy, active_side, input ready);
   modport sink   (input valid, serial_out, occupancy, active_side, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bors_lane.sv =====
// One section lane: hold timer and status bit of a single track section.
// Depends on bors_pkg for the lane control struct.
`timescale 1ns / 1ps
`default_nettype none

module bors_lane #(
   parameter logic STATUS_INIT = 1'b0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bors_pkg::bors_lane_ctrl_type ctrl,
   input  wire logic                        level,    // active low: 0 = occupied
   output logic                             status
);
   import bors_pkg::*;

   logic [TIME_W-1:0] timer_ff, timer_in;
   logic              status_ff, status_in;
   logic              hit;

   assign hit = ctrl.scan_en & ~level;

   always_comb begin
      timer_in  = timer_ff;
      status_in = status_ff;
      if (ctrl.tick_adv) begin
         timer_in = timer_ff + 1'b1;
      end else if (hit) begin
         timer_in = ctrl.restart;
      end
      // restart value is time-1, so a freshly hit section never matches
      if (hit) begin
         status_in = 1'b1;
      end else if (ctrl.rel_en && (timer_ff == ctrl.time_now)) begin
         status_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff  <= '0;
         status_ff <= STATUS_INIT;
      end else begin
         timer_ff  <= timer_in;
         status_ff <= status_in;
      end
   end

   assign status = status_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bors_ctrl.sv =====
// Scan sequencer: millisecond time, freeze flags, side select, lane control decode.
// Depends on bors_pkg for request codes and the lane control struct.
`timescale 1ns / 1ps
`default_nettype none

module bors_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [bors_pkg::REQ_W-1:0]   req_type,
   input  wire logic                         power_check_level,
   output bors_pkg::bors_lane_ctrl_type      lane_ctrl [bors_pkg::SIDES],
   output logic                              active_side
);
   import bors_pkg::*;

   logic [TIME_W-1:0] time_ff, time_in;
   logic [SIDES-1:0]  flags_ff, flags_in;
   logic              side_ff, side_in;
   logic              do_tick, do_scan;

   assign do_tick = accept && (req_type == REQ_TICK);
   assign do_scan = accept && (req_type == REQ_SCAN);

   always_comb begin
      time_in  = time_ff;
      flags_in = flags_ff;
      side_in  = side_ff;
      if (do_tick) begin
         time_in  = time_ff + 1'b1;
         flags_in = '1;
      end
      if (do_scan) begin
         side_in = ~side_ff;
         if (!power_check_level) begin
            flags_in[side_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= TIME_RESET;
         flags_ff <= '0;
         side_ff  <= 1'b0;
      end else begin
         time_ff  <= time_in;
         flags_ff <= flags_in;
         side_ff  <= side_in;
      end
   end

   for (genvar s = 0; s < SIDES; s++) begin : g_side
      logic sel;
      assign sel                   = (side_ff == 1'(s));
      assign lane_ctrl[s].tick_adv = do_tick & flags_ff[s];
      assign lane_ctrl[s].scan_en  = do_scan & sel;
      assign lane_ctrl[s].rel_en   = do_scan & sel & ~power_check_level;
      assign lane_ctrl[s].time_now = time_ff;
      assign lane_ctrl[s].restart  = time_ff - 1'b1;
   end

   assign active_side = side_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/block_occupancy_release_scanner_top.sv =====
// Top level of the block occupancy release scanner: sequencer, section lanes,
// status merge, serial shifter and response register.
// Depends on bors_pkg, bors_if, bors_ctrl and bors_lane.
`timescale 1ns / 1ps
`default_nettype none

// The response to a transfer is registered and valid in the cycle after it.
// Throughput: one request per cycle; every section lane updates in parallel,
// so the only limit is the single response register draining.
// Reset (synchronous, active high): status word 0x5048, timers 0, time 1,
// side A, freeze flags and shifter clear, no response pending.
module block_occupancy_release_scanner_top #(
   parameter int SECTIONS_PER_SIDE = bors_pkg::SECTIONS_PER_SIDE_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   bors_req_if.sink  req_chan,
   bors_rsp_if.source rsp_chan
);
   import bors_pkg::*;

   // More sections than sense levels per side behave as a full side
   localparam int LANES = (SECTIONS_PER_SIDE > LANES_MAX) ? LANES_MAX : SECTIONS_PER_SIDE;

   logic                accept;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] shift_ff, shift_in;
   logic                out_bit_ff, out_bit_in;
   logic [STATUS_W-1:0] occupancy;
   logic                active_side;
   bors_lane_ctrl_type  lane_ctrl [SIDES];

   // State only moves on an accepted transfer, and a transfer is accepted only
   // when the response slot is empty or being emptied, so the response fields
   // read straight from the state registers.
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   bors_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_type          (req_chan.req_type),
      .power_check_level (req_chan.power_check_level),
      .lane_ctrl         (lane_ctrl),
      .active_side       (active_side)
   );

   // Section lanes; lanes past the configured count keep their reset bits
   for (genvar s = 0; s < SIDES; s++) begin : g_side
      for (genvar i = 0; i < LANES_MAX; i++) begin : g_lane
         if (i < LANES) begin : g_used
            bors_lane #(
               .STATUS_INIT (STATUS_RESET[s*LANES_MAX + i])
            ) u_lane (
               .clock  (clock),
               .reset  (reset),
               .ctrl   (lane_ctrl[s]),
               .level  (req_chan.block_levels[i]),
               .status (occupancy[s*LANES_MAX + i])
            );
         end else begin : g_unused
            assign occupancy[s*LANES_MAX + i] = STATUS_RESET[s*LANES_MAX + i];
         end
      end
   end

   // Daisy-chain shifter: rise shifts right unless held, fall drives bit 0, load takes the status word
   always_comb begin
      shift_in   = shift_ff;
      out_bit_in = out_bit_ff;
      if (accept) begin
         case (req_chan.req_type)
            REQ_RISE: begin
               if (!req_chan.load_level) begin
                  shift_in = {req_chan.serial_in, shift_ff[STATUS_W-1:1]};
               end
            end
            REQ_FALL: out_bit_in = shift_ff[0];
            REQ_LOAD: shift_in   = occupancy;
            default:  ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         out_bit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         out_bit_ff   <= out_bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.serial_out  = out_bit_ff;
   assign rsp_chan.occupancy   = occupancy;
   assign rsp_chan.active_side = active_side;

endmodule

`default_nettype wire

// ===== hw/rtl/bors_checker.sv =====
// Port-level checks for the scanner top, attached by bind.
// Depends on bors_pkg and block_occupancy_release_scanner_top.
`timescale 1ns / 1ps
`default_nettype none

module bors_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [bors_pkg::REQ_W-1:0]    req_type,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_serial_out,
   input wire logic [bors_pkg::STATUS_W-1:0] rsp_occupancy,
   input wire logic                          rsp_active_side
);
   import bors_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid & req_ready;

   // Every accepted request yields a response the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("no response after accepted request");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy)
         && $stable(rsp_serial_out) && $stable(rsp_active_side))
      else $error("stalled response changed");

   // A scan flips the enabled side
   a_scan_toggles: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_type == REQ_SCAN) |=> rsp_active_side != $past(rsp_active_side))
      else $error("side did not toggle on scan");

   // The serial output changes only on a clock fall request
   a_out_on_fall: assert property (@(posedge clock) disable iff (reset)
      !(req_xfer && (req_type == REQ_FALL)) |=> $stable(rsp_serial_out))
      else $error("serial output changed without clock fall");

endmodule

bind block_occupancy_release_scanner_top bors_checker u_bors_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_type        (req_chan.req_type),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_serial_out  (rsp_chan.serial_out),
   .rsp_occupancy   (rsp_chan.occupancy),
   .rsp_active_side (rsp_chan.active_side)
);

`default_nettype wire

// ===== test/block_occupancy_release_scanner_top_test.sv =====
// Self-checking testbench for the block occupancy release scanner top level.
// Depends on bors_pkg, bors_if and the block_occupancy_release_scanner_top RTL.
// Compares every response against a cycle-free model of the section state.
`timescale 1ns / 1ps

module block_occupancy_release_scanner_top_test;
   import bors_pkg::*;

   // Sections per side on the instance, and the lanes that actually exist
   localparam int SECTIONS = SECTIONS_PER_SIDE_DEF;
   localparam int LANES    = (SECTIONS < LANES_MAX) ? SECTIONS : LANES_MAX;

   // Codes 5..7 are not decoded by the block; they must leave the state alone
   localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNUSED_MID   = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

   // Watchdog limit for a run of ~2000 transfers
   localparam int CYCLE_LIMIT = 400000;

   // One request as it goes on the wire
   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic [7:0]       levels;     // active low: 0 = section occupied
      logic             power_off;  // 1 = no track power seen on this scan
      logic             sdata;
      logic             hold;       // load level on a clock rise
   } track_event_type;

   // One response: serial bit, status word, side for the next scan
   typedef struct packed {
      logic                sout;
      logic [STATUS_W-1:0] occ;
      logic                side;
   } status_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bors_req_if req_chan ();
   bors_rsp_if rsp_chan ();

   block_occupancy_release_scanner_top #(
      .SECTIONS_PER_SIDE(SECTIONS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Section state as the block should hold it after each transfer
   // ------------------------------------------------------------------
   logic [STATUS_W-1:0] status_m      = STATUS_RESET;
   logic [TIME_W-1:0]   hold_timer_m [SIDES*LANES_MAX];
   logic [TIME_W-1:0]   time_m        = TIME_RESET;
   logic [SIDES-1:0]    advance_m     = '0;   // bit set: side timers count on a tick
   logic                side_m        = 1'b0;
   logic [STATUS_W-1:0] shifter_m     = '0;
   logic                out_bit_m     = 1'b0;

   initial begin
      foreach (hold_timer_m[k]) hold_timer_m[k] = '0;
   end

   // Applies one accepted request to the section state and returns the
   // response the block owes for it.
   task automatic apply_track_event(input track_event_type ev,
                                    output status_report_type rep);
      int unsigned       base;
      logic [TIME_W-1:0] restart;
      case (ev.kind)
         REQ_TICK: begin
            time_m = time_m + 1'b1;
            for (int s = 0; s < SIDES; s++) begin
               if (advance_m[s]) begin
                  for (int i = 0; i < LANES; i++)
                     hold_timer_m[s*LANES_MAX+i] = hold_timer_m[s*LANES_MAX+i] + 1'b1;
               end
            end
            advance_m = '1;
         end
         REQ_SCAN: begin
            base    = side_m * LANES_MAX;
            restart = time_m - 1'b1;
            // Occupied sections are marked even without power
            for (int i = 0; i < LANES; i++) begin
               if (!ev.levels[i]) begin
                  hold_timer_m[base+i] = restart;
                  status_m[base+i]     = 1'b1;
               end
            end
            // With power: freeze this side's timers and release expired sections
            if (!ev.power_off) begin
               advance_m[side_m] = 1'b0;
               for (int i = 0; i < LANES; i++) begin
                  if (hold_timer_m[base+i] == time_m)
                     status_m[base+i] = 1'b0;
               end
            end
            side_m = ~side_m;
         end
         REQ_RISE: begin
            if (!ev.hold)
               shifter_m = {ev.sdata, shifter_m[STATUS_W-1:1]};
         end
         REQ_FALL: out_bit_m = shifter_m[0];
         REQ_LOAD: shifter_m = status_m;
         default: ;
      endcase
      rep = '{sout: out_bit_m, occ: status_m, side: side_m};
   endtask

   // Request with every field random; callers pin the fields that matter
   function automatic track_event_type make_event(logic [REQ_W-1:0] kind);
      track_event_type ev;
      ev           = track_event_type'($bits(track_event_type)'($urandom));
      ev.kind      = kind;
      return ev;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus and bookkeeping
   // ------------------------------------------------------------------
   track_event_type   pending_events [$];
   status_report_type expected_reports [$];
   int unsigned       failures    = 0;
   int unsigned       cycle_count = 0;

   // Transfer flags from the last rising edge, read by the falling-edge drivers
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   // Request driver: holds each item until its transfer, then waits a drawn gap
   track_event_type drive_ev;
   int unsigned     req_wait  = 0;
   bit              req_burst = 1'b0;

   always @(negedge clock) begin
      if (!reset && !(req_chan.valid && !req_took)) begin
         if (req_wait != 0) begin
            req_wait--;
            req_chan.valid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            drive_ev = pending_events.pop_front();
            req_chan.req_type          <= drive_ev.kind;
            req_chan.block_levels      <= drive_ev.levels;
            req_chan.power_check_level <= drive_ev.power_off;
            req_chan.serial_in         <= drive_ev.sdata;
            req_chan.load_level        <= drive_ev.hold;
            req_chan.valid             <= 1'b1;
            // Occasionally flip into or out of back-to-back mode
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
            req_wait = req_burst ? 0 : $urandom_range(0, 11);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response sink: after each transfer, stall ready for a drawn count
   int unsigned rsp_stall = 0;
   bit          rsp_burst = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 11);
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: check responses against the oldest expectation, then predict
   // the response for any request transferred on this edge.
   status_report_type want_rep, next_rep;
   track_event_type   seen_ev;

   always @(posedge clock) begin
      req_took <= req_chan.valid && req_chan.ready;
      rsp_took <= rsp_chan.valid && rsp_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: response with none expected: serial_out %0b occupancy %h side %0b",
                        $time, rsp_chan.serial_out, rsp_chan.occupancy, rsp_chan.active_side);
               failures++;
            end else begin
               want_rep = expected_reports.pop_front();
               if (rsp_chan.serial_out !== want_rep.sout) begin
                  $display("%0t: serial_out expected %0b actual %0b",
                           $time, want_rep.sout, rsp_chan.serial_out);
                  failures++;
               end
               if (rsp_chan.occupancy !== want_rep.occ) begin
                  $display("%0t: occupancy expected %h actual %h",
                           $time, want_rep.occ, rsp_chan.occupancy);
                  failures++;
               end
               if (rsp_chan.active_side !== want_rep.side) begin
                  $display("%0t: active_side expected %0b actual %0b",
                           $time, want_rep.side, rsp_chan.active_side);
                  failures++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen_ev = '{kind: req_chan.req_type, levels: req_chan.block_levels,
                        power_off: req_chan.power_check_level,
                        sdata: req_chan.serial_in, hold: req_chan.load_level};
            apply_track_event(seen_ev, next_rep);
            expected_reports.push_back(next_rep);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("block_occupancy_release_scanner_top_test NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      track_event_type ev;
      bit              quiet;

      req_chan.valid             = 1'b0;
      req_chan.req_type          = REQ_TICK;
      req_chan.block_levels      = '1;
      req_chan.power_check_level = 1'b1;
      req_chan.serial_in         = 1'b0;
      req_chan.load_level        = 1'b1;
      rsp_chan.ready             = 1'b0;

      // --- directed part ---
      // Unused codes first: they must report the identification pattern
      pending_events.push_back(make_event(REQ_UNUSED_FIRST));
      pending_events.push_back(make_event(REQ_UNUSED_MID));
      pending_events.push_back(make_event(REQ_UNUSED_LAST));
      // Load the status word, fall drives bit 0 (clear in the pattern)
      pending_events.push_back(make_event(REQ_LOAD));
      pending_events.push_back(make_event(REQ_FALL));
      // Clock rise while held must ignore serial data
      ev = make_event(REQ_RISE); ev.hold = 1'b1; ev.sdata = 1'b1;
      pending_events.push_back(ev);
      // Three shifts bring a set bit to position 0, ones and zeros shifted in
      ev = make_event(REQ_RISE); ev.hold = 1'b0; ev.sdata = 1'b1;
      pending_events.push_back(ev);
      ev = make_event(REQ_RISE); ev.hold = 1'b0; ev.sdata = 1'b0;
      pending_events.push_back(ev);
      ev = make_event(REQ_RISE); ev.hold = 1'b0; ev.sdata = 1'b1;
      pending_events.push_back(ev);
      pending_events.push_back(make_event(REQ_FALL));
      // Side A all occupied with power, side B empty without power
      ev = make_event(REQ_SCAN); ev.levels = 8'h00; ev.power_off = 1'b0;
      pending_events.push_back(ev);
      ev = make_event(REQ_SCAN); ev.levels = 8'hFF; ev.power_off = 1'b1;
      pending_events.push_back(ev);
      pending_events.push_back(make_event(REQ_TICK));
      ev = make_event(REQ_SCAN); ev.levels = 8'hFF; ev.power_off = 1'b0;
      pending_events.push_back(ev);
      // Occupied without power: marked but timers keep running
      ev = make_event(REQ_SCAN); ev.levels = 8'h5A; ev.power_off = 1'b1;
      pending_events.push_back(ev);
      pending_events.push_back(make_event(REQ_TICK));
      ev = make_event(REQ_SCAN); ev.levels = 8'h7E; ev.power_off = 1'b0;
      pending_events.push_back(ev);
      ev = make_event(REQ_SCAN); ev.levels = 8'hFF; ev.power_off = 1'b0;
      pending_events.push_back(ev);
      pending_events.push_back(make_event(REQ_LOAD));
      pending_events.push_back(make_event(REQ_FALL));

      // --- random part ---
      // Rounds of tick + one scan per side, as the block is normally paced.
      // Each set opens with a busy stretch that occupies sections, then a
      // long quiet stretch with power so the hold timers run out and the
      // sections are released (about 255 rounds after last occupied).
      for (int set_i = 0; set_i < 2; set_i++) begin
         for (int round = 0; round < 300; round++) begin
            quiet = (round >= 30);
            pending_events.push_back(make_event(REQ_TICK));
            repeat (2) begin
               ev = make_event(REQ_SCAN);
               if (quiet) begin
                  ev.levels    = 8'hFF;
                  if ($urandom_range(0, 63) == 0) ev.levels[$urandom_range(0, 7)] = 1'b0;
                  ev.power_off = ($urandom_range(0, 63) == 0);
               end else begin
                  ev.levels    = 8'($urandom | $urandom);
                  ev.power_off = ($urandom_range(0, 7) == 0);
               end
               pending_events.push_back(ev);
            end
            // Shift chain traffic mixed in
            if ($urandom_range(0, 3) == 0) begin
               ev = make_event(REQ_W'($urandom_range(REQ_RISE, REQ_LOAD)));
               ev.hold = ($urandom_range(0, 3) == 0);
               pending_events.push_back(ev);
            end
            // Noise: unused codes, stray ticks and scans out of pattern
            if ($urandom_range(0, 39) == 0)
               pending_events.push_back(
                  make_event(REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST))));
            if ($urandom_range(0, 49) == 0)
               pending_events.push_back(make_event(REQ_W'($urandom_range(REQ_TICK, REQ_SCAN))));
         end
      end

      // Synchronous reset, released on a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: every item transferred and every response seen
      do
         @(negedge clock);
      while (pending_events.size() != 0 || req_chan.valid || expected_reports.size() != 0);
      // Spare cycles afterwards catch stray responses
      repeat (4) @(negedge clock);

      if (failures == 0)
         $display("block_occupancy_release_scanner_top_test OK");
      else
         $display("block_occupancy_release_scanner_top_test NOT OK");
      $finish;
   end

endmodule

// ===== block_occupancy_release_scanner_top.f =====
hw/rtl/bors_pkg.sv
hw/rtl/bors_if.sv
hw/rtl/bors_lane.sv
hw/rtl/bors_ctrl.sv
hw/rtl/block_occupancy_release_scanner_top.sv
hw/rtl/bors_checker.sv
test/block_occupancy_release_scanner_top_test.sv
